// File: rtl/core/ovns_pkg.sv
// Shared types, constants and arithmetic helpers for the octave value noise sampler.
package ovns_pkg;

    localparam int ADDR_W      = 10;
    localparam int VALUE_W     = 16;
    localparam int COORD_W     = 16;
    localparam int OUT_W       = 18;
    localparam int CFG_W       = 3;
    localparam int MEM_CAP     = 1024;
    localparam int MID_DEPTH   = 2;
    localparam int OUT_DEPTH   = 8;
    localparam logic [OUT_W-1:0] OUT_MAX = 18'h3FFFF;
    localparam logic [CFG_W-1:0] OCTAVES_RESET = 3'd4;

    typedef enum logic [0:0] {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [1:0]          octave_sel;
        logic [ADDR_W-1:0]   entry_addr;
        logic [VALUE_W-1:0]  entry_value;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  idx00;
        logic [ADDR_W-1:0]  idx01;
        logic [ADDR_W-1:0]  idx10;
        logic [ADDR_W-1:0]  idx11;
        logic [15:0]        xr;
        logic [15:0]        yr;
    } geom_t;

    // Fade entry sin^2(pi*i/2^(fbits+1)) in Q0.16 from a Q30 Taylor series.
    function automatic logic [16:0] fade_value(int unsigned idx, int unsigned fbits);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] q;
        t    = (64'd1686629713 * 64'(idx)) >> fbits;
        t2   = (t * t) >> 30;
        term = t;
        s    = t;
        term = ((term * t2) >> 30) / 64'd6;
        s    = s - term;
        term = ((term * t2) >> 30) / 64'd20;
        s    = s + term;
        term = ((term * t2) >> 30) / 64'd42;
        s    = s - term;
        term = ((term * t2) >> 30) / 64'd72;
        s    = s + term;
        term = ((term * t2) >> 30) / 64'd110;
        s    = s - term;
        term = ((term * t2) >> 30) / 64'd156;
        s    = s + term;
        term = ((term * t2) >> 30) / 64'd210;
        s    = s - term;
        q    = (s * s + (64'd1 << 43)) >> 44;
        return q[16:0];
    endfunction

    function automatic logic [15:0] interp(logic [15:0] a, logic [15:0] b, logic [16:0] f);
        logic [33:0] s;
        s = 34'(18'h10000 - 18'(f)) * 34'(a) + 34'(f) * 34'(b);
        return s[31:16];
    endfunction

    function automatic logic [15:0] octave_mix(logic [15:0] iy0, logic [15:0] iy1,
                                               logic [15:0] ix0, logic [15:0] ix1,
                                               logic [15:0] xr, logic [15:0] yr);
        logic [34:0] s;
        s = 35'(18'h10000 - 18'(xr)) * 35'(iy0) + 35'(xr) * 35'(iy1)
          + 35'(18'h10000 - 18'(yr)) * 35'(ix0) + 35'(yr) * 35'(ix1);
        return s[32:17];
    endfunction

endpackage

// File: rtl/core/ovns_fifo.sv
// Small register queue used between the front and back parts and on the result side.
module ovns_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [W-1:0]                 wdata,
    input  logic                         pop,
    output logic                         empty,
    output logic [W-1:0]                 rdata,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/core/ovns_front.sv
// Front part: classifies a word and works out each octave's cell corners and fractions.
module ovns_front #(
    parameter int BASE_DIM    = 4,
    parameter int MAX_OCTAVES = 4,
    parameter int COORD_BITS  = 16
) (
    input  logic [0:0]                                cmd,
    input  logic [1:0]                                octave_sel,
    input  logic [ovns_pkg::ADDR_W-1:0]               entry_addr,
    input  logic [ovns_pkg::VALUE_W-1:0]              entry_value,
    input  logic [ovns_pkg::COORD_W-1:0]              coord_x,
    input  logic [ovns_pkg::COORD_W-1:0]              coord_y,
    output ovns_pkg::item_t                           item,
    output ovns_pkg::geom_t [MAX_OCTAVES-1:0]         geom
);
    import ovns_pkg::*;

    logic [COORD_BITS-1:0] xc;
    logic [COORD_BITS-1:0] yc;

    assign xc = COORD_BITS'(coord_x);
    assign yc = COORD_BITS'(coord_y);

    assign item.cmd         = cmd_t'(cmd);
    assign item.octave_sel  = octave_sel;
    assign item.entry_addr  = entry_addr;
    assign item.entry_value = entry_value;

    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_oct
        localparam int SIDE = BASE_DIM << k;
        localparam int SXW  = (SIDE > 1) ? $clog2(SIDE) : 1;
        localparam int PW   = COORD_BITS + SXW;

        logic [PW-1:0]          px;
        logic [PW-1:0]          py;
        logic [SXW-1:0]         x0;
        logic [SXW-1:0]         y0;
        logic [SXW-1:0]         x1;
        logic [SXW-1:0]         y1;
        logic [COORD_BITS+15:0] fx_ext;
        logic [COORD_BITS+15:0] fy_ext;
        logic [31:0]            i00;
        logic [31:0]            i01;
        logic [31:0]            i10;
        logic [31:0]            i11;

        always_comb
        begin
            px = PW'(xc) * PW'(SIDE);
            py = PW'(yc) * PW'(SIDE);
            x0 = px[PW-1:COORD_BITS];
            y0 = py[PW-1:COORD_BITS];
            if (32'(x0) > SIDE - 1)
            begin
                x0 = SXW'(SIDE - 1);
            end
            if (32'(y0) > SIDE - 1)
            begin
                y0 = SXW'(SIDE - 1);
            end
            x1 = (32'(x0) == SIDE - 1) ? x0 : x0 + 1'b1;
            y1 = (32'(y0) == SIDE - 1) ? y0 : y0 + 1'b1;
            fx_ext = {px[COORD_BITS-1:0], 16'b0};
            fy_ext = {py[COORD_BITS-1:0], 16'b0};
            i00 = 32'(x0) * 32'(SIDE) + 32'(y0);
            i01 = 32'(x0) * 32'(SIDE) + 32'(y1);
            i10 = 32'(x1) * 32'(SIDE) + 32'(y0);
            i11 = 32'(x1) * 32'(SIDE) + 32'(y1);
        end

        assign geom[k].idx00 = i00[ADDR_W-1:0];
        assign geom[k].idx01 = i01[ADDR_W-1:0];
        assign geom[k].idx10 = i10[ADDR_W-1:0];
        assign geom[k].idx11 = i11[ADDR_W-1:0];
        assign geom[k].xr    = fx_ext[COORD_BITS +: 16];
        assign geom[k].yr    = fy_ext[COORD_BITS +: 16];
    end

endmodule

// File: rtl/core/ovns_back.sv
// Back part: lattice memories, fade lookup, interpolation pipeline and octave sum.
module ovns_back #(
    parameter int BASE_DIM      = 4,
    parameter int MAX_OCTAVES   = 4,
    parameter int FADE_LUT_BITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   mid_empty,
    output logic                                   mid_pop,
    input  ovns_pkg::item_t                        mid_item,
    input  ovns_pkg::geom_t [MAX_OCTAVES-1:0]      mid_geom,
    input  logic [ovns_pkg::CFG_W-1:0]             active_octaves,
    input  logic [$clog2(ovns_pkg::OUT_DEPTH+1)-1:0] out_count,
    output logic                                   out_push,
    output logic [ovns_pkg::OUT_W-1:0]             out_value
);
    import ovns_pkg::*;

    localparam int FADE_SIZE = 1 << FADE_LUT_BITS;
    localparam int TW        = 17 + $clog2(MAX_OCTAVES);

    logic [16:0]                  fade_rom [FADE_SIZE];
    logic                         s1_valid_reg;
    item_t                        s1_item_reg;
    geom_t [MAX_OCTAVES-1:0]      s1_geom_reg;
    logic                         s2_valid_reg;
    logic                         s3_valid_reg;
    logic                         s4_valid_reg;
    logic [2:0]                   inflight;
    logic                         s1_sample;
    logic [MAX_OCTAVES-1:0][15:0] oct_val;
    logic [TW-1:0]                total;

    for (genvar i = 0; i < FADE_SIZE; i++)
    begin : g_fade
        assign fade_rom[i] = fade_value(i, FADE_LUT_BITS);
    end

    assign s1_sample = s1_valid_reg && (s1_item_reg.cmd == CMD_SAMPLE);
    assign inflight  = 3'(s1_sample) + 3'(s2_valid_reg) + 3'(s3_valid_reg)
                     + 3'(s4_valid_reg);
    assign mid_pop   = !mid_empty && (32'(out_count) + 32'(inflight) < OUT_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= mid_pop;
            s2_valid_reg <= s1_sample;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            s1_item_reg <= mid_item;
            s1_geom_reg <= mid_geom;
        end
    end

    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_oct
        localparam int SIDE  = BASE_DIM << k;
        localparam int SQ    = SIDE * SIDE;
        localparam int DEPTH = (SQ > MEM_CAP) ? MEM_CAP : SQ;
        localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

        logic [15:0] mem00 [DEPTH];
        logic [15:0] mem01 [DEPTH];
        logic [15:0] mem10 [DEPTH];
        logic [15:0] mem11 [DEPTH];
        logic        we;
        logic [15:0] v00_reg;
        logic [15:0] v01_reg;
        logic [15:0] v10_reg;
        logic [15:0] v11_reg;
        logic [16:0] fx_reg;
        logic [16:0] fy_reg;
        logic [15:0] xr2_reg;
        logic [15:0] yr2_reg;
        logic [15:0] iy0_reg;
        logic [15:0] iy1_reg;
        logic [15:0] ix0_reg;
        logic [15:0] ix1_reg;
        logic [15:0] xr3_reg;
        logic [15:0] yr3_reg;
        logic [15:0] oct_reg;

        assign we = s1_valid_reg && (s1_item_reg.cmd == CMD_WRITE)
                 && (32'(s1_item_reg.octave_sel) == k)
                 && (32'(s1_item_reg.entry_addr) < SQ);

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem00[s1_item_reg.entry_addr[AW-1:0]] <= s1_item_reg.entry_value;
                mem01[s1_item_reg.entry_addr[AW-1:0]] <= s1_item_reg.entry_value;
                mem10[s1_item_reg.entry_addr[AW-1:0]] <= s1_item_reg.entry_value;
                mem11[s1_item_reg.entry_addr[AW-1:0]] <= s1_item_reg.entry_value;
            end
            v00_reg <= mem00[s1_geom_reg[k].idx00[AW-1:0]];
            v01_reg <= mem01[s1_geom_reg[k].idx01[AW-1:0]];
            v10_reg <= mem10[s1_geom_reg[k].idx10[AW-1:0]];
            v11_reg <= mem11[s1_geom_reg[k].idx11[AW-1:0]];
            fx_reg  <= fade_rom[s1_geom_reg[k].xr[15 -: FADE_LUT_BITS]];
            fy_reg  <= fade_rom[s1_geom_reg[k].yr[15 -: FADE_LUT_BITS]];
            xr2_reg <= s1_geom_reg[k].xr;
            yr2_reg <= s1_geom_reg[k].yr;
            iy0_reg <= interp(v00_reg, v01_reg, fy_reg);
            iy1_reg <= interp(v10_reg, v11_reg, fy_reg);
            ix0_reg <= interp(v00_reg, v10_reg, fx_reg);
            ix1_reg <= interp(v01_reg, v11_reg, fx_reg);
            xr3_reg <= xr2_reg;
            yr3_reg <= yr2_reg;
            oct_reg <= octave_mix(iy0_reg, iy1_reg, ix0_reg, ix1_reg, xr3_reg, yr3_reg);
        end

        assign oct_val[k] = oct_reg;
    end

    always_comb
    begin
        total = '0;
        for (int k = 0; k < MAX_OCTAVES; k++)
        begin
            if (32'(active_octaves) > k)
            begin
                total = total + TW'(oct_val[k]);
            end
        end
    end

    assign out_push  = s4_valid_reg;
    assign out_value = (32'(total) > 32'(OUT_MAX)) ? OUT_MAX : OUT_W'(total);

endmodule

// File: rtl/core/octave_value_noise_sampler_top.sv
// Top level of the octave value noise sampler: front, middle queue, back and result queue.
//
//   Channel   Handshake            Payload
//   input     push / full          cmd, octave_sel, entry_addr, entry_value, coord_x, coord_y
//   result    empty / pop          noise_value
//   config    cfg_valid / cfg_ready  cfg_data (active_octaves)
//
// One word is accepted per cycle unless full; results go via the back pipeline to the result queue.
// The rate is set by the back pipeline, which reads four copies of each octave's table per cycle.
// Reset empties the queues, clears pipeline valids, loads OCTAVES_RESET; tables hold no reset value.
// A stalled result side fills the result queue and then the middle queue, after which full rises.
module octave_value_noise_sampler_top #(
    parameter int BASE_DIM      = 4,
    parameter int MAX_OCTAVES   = 4,
    parameter int COORD_BITS    = 16,
    parameter int FADE_LUT_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [0:0]                     cmd,
    input  logic [1:0]                     octave_sel,
    input  logic [ovns_pkg::ADDR_W-1:0]    entry_addr,
    input  logic [ovns_pkg::VALUE_W-1:0]   entry_value,
    input  logic [ovns_pkg::COORD_W-1:0]   coord_x,
    input  logic [ovns_pkg::COORD_W-1:0]   coord_y,
    output logic                           empty,
    input  logic                           pop,
    output logic [ovns_pkg::OUT_W-1:0]     noise_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ovns_pkg::CFG_W-1:0]     cfg_data
);
    import ovns_pkg::*;

    localparam int MW = $bits(item_t) + MAX_OCTAVES * $bits(geom_t);

    item_t                               front_item;
    geom_t [MAX_OCTAVES-1:0]             front_geom;
    item_t                               mid_item;
    geom_t [MAX_OCTAVES-1:0]             mid_geom;
    logic                                mid_empty;
    logic                                mid_pop;
    logic [$clog2(OUT_DEPTH+1)-1:0]      out_count;
    logic                                out_push;
    logic [OUT_W-1:0]                    out_value;
    logic [CFG_W-1:0]                    octaves_reg;
    logic [CFG_W-1:0]                    octaves_used;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octaves_reg <= OCTAVES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            octaves_reg <= cfg_data;
        end
    end

    assign octaves_used = (32'(octaves_reg) > MAX_OCTAVES) ? CFG_W'(MAX_OCTAVES) : octaves_reg;

    ovns_front #(
        .BASE_DIM    (BASE_DIM),
        .MAX_OCTAVES (MAX_OCTAVES),
        .COORD_BITS  (COORD_BITS)
    ) u_front (
        .cmd         (cmd),
        .octave_sel  (octave_sel),
        .entry_addr  (entry_addr),
        .entry_value (entry_value),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .item        (front_item),
        .geom        (front_geom)
    );

    ovns_fifo #(
        .W     (MW),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata ({front_item, front_geom}),
        .pop   (mid_pop),
        .empty (mid_empty),
        .rdata ({mid_item, mid_geom}),
        .count ()
    );

    ovns_back #(
        .BASE_DIM      (BASE_DIM),
        .MAX_OCTAVES   (MAX_OCTAVES),
        .FADE_LUT_BITS (FADE_LUT_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .mid_empty      (mid_empty),
        .mid_pop        (mid_pop),
        .mid_item       (mid_item),
        .mid_geom       (mid_geom),
        .active_octaves (octaves_used),
        .out_count      (out_count),
        .out_push       (out_push),
        .out_value      (out_value)
    );

    ovns_fifo #(
        .W     (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .full  (),
        .wdata (out_value),
        .pop   (pop),
        .empty (empty),
        .rdata (noise_value),
        .count (out_count)
    );

endmodule

// File: rtl/core/ovns_checker.sv
// Port-level checks for the octave value noise sampler and their bind to the top level.
module ovns_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           push,
    input logic                           full,
    input logic [0:0]                     cmd,
    input logic                           empty,
    input logic                           pop,
    input logic [ovns_pkg::OUT_W-1:0]     noise_value,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);
    import ovns_pkg::*;

    logic [7:0] pending_reg;
    logic [7:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if (push && !full && (cmd == CMD_SAMPLE))
        begin
            pending_next = pending_next + 8'd1;
        end
        if (pop && !empty)
        begin
            pending_next = pending_next - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A waiting result word stays until it is popped.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result word dropped before pop");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(noise_value))
        else $error("result word changed while waiting");

    // No result word appears without an outstanding sample.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 8'd0) |-> empty)
        else $error("result word without a pending sample");

    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration word not taken");

endmodule

bind octave_value_noise_sampler_top ovns_checker u_ovns_checker (.*);
